/* rtl/hrd_pkg.sv */
`default_nettype none

package hrd_pkg;

  localparam int MAX_KEY_SLOTS = 6;
  localparam int SLOT_INDEX_BITS = $clog2(MAX_KEY_SLOTS);
  localparam int REPORT_BYTES = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] SHIFT_MASK_RESET = 8'h22;
  localparam logic [3:0] WHEEL_SCALE_RESET = 4'd3;

  typedef enum logic [0:0] {
    CFG_SHIFT_MASK  = 1'b0,
    CFG_WHEEL_SCALE = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KEY_PRINTABLE = 2'd0,
    KEY_NAMED     = 2'd1,
    KEY_FUNCTION  = 2'd2
  } key_class_t;

  typedef enum logic [0:0] {
    EVENT_KEY   = 1'b0,
    EVENT_MOUSE = 1'b1
  } event_kind_t;

  typedef struct packed {
    logic       mapped;
    key_class_t cls;
    logic [6:0] ch;
    logic [3:0] fn;
  } key_map_t;

  typedef struct packed {
    logic                              is_mouse;
    logic [7:0]                        mods;
    logic                              shifted;
    logic [MAX_KEY_SLOTS-1:0]          mask;
    logic [MAX_KEY_SLOTS-1:0][7:0]     keys;
    logic [2:0]                        buttons;
    logic [7:0]                        dx;
    logic [7:0]                        dy;
    logic [7:0]                        wheel;
  } job_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  mods;
    logic [7:0]  key_code;
    key_class_t  key_class;
    logic [6:0]  char_code;
    logic [3:0]  function_number;
    logic [15:0] dx_total;
    logic [15:0] dy_total;
    logic        left;
    logic        right;
    logic        middle;
    logic        last;
  } event_t;

  function automatic logic [6:0] shifted_digit(input logic [3:0] idx);
    logic [6:0] c;
    case (idx)
      4'd0:    c = 7'h21;
      4'd1:    c = 7'h40;
      4'd2:    c = 7'h23;
      4'd3:    c = 7'h24;
      4'd4:    c = 7'h25;
      4'd5:    c = 7'h5E;
      4'd6:    c = 7'h26;
      4'd7:    c = 7'h2A;
      4'd8:    c = 7'h28;
      default: c = 7'h29;
    endcase
    return c;
  endfunction

  function automatic key_map_t map_key(input logic [7:0] key, input logic shifted);
    key_map_t   m;
    logic [7:0] d;
    m = '{mapped: 1'b0, cls: KEY_PRINTABLE, ch: 7'd0, fn: 4'd0};
    d = 8'd0;
    if (key inside {[8'h28:8'h2C], [8'h4F:8'h52]}) begin
      m.mapped = 1'b1;
      m.cls = KEY_NAMED;
    end else if (key inside {[8'h3A:8'h45]}) begin
      d = key - 8'h39;
      m.mapped = 1'b1;
      m.cls = KEY_FUNCTION;
      m.fn = d[3:0];
    end else if (key inside {[8'h04:8'h1D]}) begin
      d = key - 8'h04 + (shifted ? 8'h41 : 8'h61);
      m.mapped = 1'b1;
      m.ch = d[6:0];
    end else if (key inside {[8'h1E:8'h26]}) begin
      d = key - 8'h1E;
      m.mapped = 1'b1;
      m.ch = shifted ? shifted_digit(d[3:0]) : 7'h31 + d[6:0];
    end else if (key == 8'h27) begin
      m.mapped = 1'b1;
      m.ch = shifted ? 7'h29 : 7'h30;
    end
    return m;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hid_report_decoder.sv */
// Decodes HID boot reports into key press events and mouse state updates.
// The input channel takes one report per item: its length and nine bytes.
// A keyboard report (8 or 9 bytes) gives one key event per newly pressed,
// mapped key, in slot order; a mouse report (3 to 7 bytes) gives one update
// with the saturated dx and dy totals and the buttons. Other lengths give
// nothing. last_of_run marks the final result of each report.
// The first result of a report passes from the queue through the job register
// to the output register. The back end issues one result per cycle while
// out_stall is low; a queue of two decoded reports lets the front keep
// accepting meanwhile, at one report per cycle as long as the back end keeps
// up. in_stall is high while that queue is full.
// When out_stall is high the current result holds in the output register,
// the back end pauses, and the queue fills up until in_stall rises.
// The configuration port is always ready; write only while the block is idle.
// Reset clears the stored key slots, both totals and the queue, and loads
// shift_mask 0x22 and wheel_scale 3.
`default_nettype none

module hid_report_decoder #(
  parameter int KEY_SLOTS = hrd_pkg::MAX_KEY_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_report_length,
  input  wire logic [7:0]  in_report_byte_0,
  input  wire logic [7:0]  in_report_byte_1,
  input  wire logic [7:0]  in_report_byte_2,
  input  wire logic [7:0]  in_report_byte_3,
  input  wire logic [7:0]  in_report_byte_4,
  input  wire logic [7:0]  in_report_byte_5,
  input  wire logic [7:0]  in_report_byte_6,
  input  wire logic [7:0]  in_report_byte_7,
  input  wire logic [7:0]  in_report_byte_8,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_event_kind,
  output logic [7:0]       out_modifier_bits,
  output logic [7:0]       out_key_code,
  output logic [1:0]       out_key_class,
  output logic [6:0]       out_char_code,
  output logic [3:0]       out_function_number,
  output logic signed [15:0] out_dx_total,
  output logic signed [15:0] out_dy_total,
  output logic             out_left_pressed,
  output logic             out_right_pressed,
  output logic             out_middle_pressed,
  output logic             out_last_of_run,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0] shift_mask_r, shift_mask_nxt;
  logic [3:0] wheel_scale_r, wheel_scale_nxt;

  logic [hrd_pkg::REPORT_BYTES-1:0][7:0] in_bytes;
  logic            queue_full;
  logic            queue_empty;
  logic            push;
  logic            pop;
  hrd_pkg::job_t   front_job;
  hrd_pkg::job_t   queue_job;
  hrd_pkg::event_t evt;

  assign cfg_ready = 1'b1;

  always_comb begin
    shift_mask_nxt = shift_mask_r;
    wheel_scale_nxt = wheel_scale_r;
    if (cfg_valid) begin
      case (hrd_pkg::cfg_index_t'(cfg_index))
        hrd_pkg::CFG_SHIFT_MASK:  shift_mask_nxt = cfg_data;
        hrd_pkg::CFG_WHEEL_SCALE: wheel_scale_nxt = cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_mask_r <= hrd_pkg::SHIFT_MASK_RESET;
      wheel_scale_r <= hrd_pkg::WHEEL_SCALE_RESET;
    end else begin
      shift_mask_r <= shift_mask_nxt;
      wheel_scale_r <= wheel_scale_nxt;
    end
  end

  assign in_bytes = {in_report_byte_8, in_report_byte_7, in_report_byte_6,
                     in_report_byte_5, in_report_byte_4, in_report_byte_3,
                     in_report_byte_2, in_report_byte_1, in_report_byte_0};

  hrd_front #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_len     (in_report_length),
    .in_bytes   (in_bytes),
    .shift_mask (shift_mask_r),
    .queue_full (queue_full),
    .push       (push),
    .job        (front_job)
  );

  hrd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (front_job),
    .pop     (pop),
    .full    (queue_full),
    .empty   (queue_empty),
    .job_out (queue_job)
  );

  hrd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .wheel_scale (wheel_scale_r),
    .q_empty     (queue_empty),
    .q_job       (queue_job),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .evt         (evt)
  );

  assign out_event_kind = evt.kind;
  assign out_modifier_bits = evt.mods;
  assign out_key_code = evt.key_code;
  assign out_key_class = evt.key_class;
  assign out_char_code = evt.char_code;
  assign out_function_number = evt.function_number;
  assign out_dx_total = $signed(evt.dx_total);
  assign out_dy_total = $signed(evt.dy_total);
  assign out_left_pressed = evt.left;
  assign out_right_pressed = evt.right;
  assign out_middle_pressed = evt.middle;
  assign out_last_of_run = evt.last;

  a_mouse_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind |-> out_last_of_run)
    else $error("mouse update not marked as last of its report");

  a_mouse_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind |-> out_key_code == 8'd0 && out_modifier_bits == 8'd0)
    else $error("mouse update carries key fields");

  a_key_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_kind |-> out_dx_total == 16'sd0 && out_dy_total == 16'sd0
      && out_key_code != 8'd0)
    else $error("key event carries mouse fields or an empty key code");

  a_fn_only_function: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_function_number != 4'd0 |-> out_key_class == hrd_pkg::KEY_FUNCTION
      && out_char_code == 7'd0)
    else $error("function number on a key that is not a function key");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    queue_empty |-> !pop)
    else $error("back end took a job from an empty queue");

endmodule

`default_nettype wire

/* rtl/hrd_front.sv */
`default_nettype none

module hrd_front #(
  parameter int KEY_SLOTS = hrd_pkg::MAX_KEY_SLOTS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [3:0]                           in_len,
  input  wire logic [hrd_pkg::REPORT_BYTES-1:0][7:0] in_bytes,
  input  wire logic [7:0]                           shift_mask,
  input  wire logic                                 queue_full,
  output logic                                      push,
  output hrd_pkg::job_t                             job
);

  logic [KEY_SLOTS-1:0][7:0] prev_keys_r;
  logic [KEY_SLOTS-1:0][7:0] prev_keys_nxt;

  logic                                     accept;
  logic                                     is_kbd;
  logic                                     is_mouse;
  logic                                     has_id;
  logic [hrd_pkg::MAX_KEY_SLOTS-1:0][7:0]   keys;
  logic [hrd_pkg::MAX_KEY_SLOTS-1:0]        mask;
  logic [7:0]                               mods;
  logic                                     hit;
  hrd_pkg::key_map_t                        km;

  always_comb begin
    is_kbd = (in_len == 4'd8) || (in_len == 4'd9);
    is_mouse = (in_len >= 4'd3) && (in_len <= 4'd7);
    accept = in_valid && !queue_full;
    in_stall = queue_full;

    mods = (in_len == 4'd9) ? in_bytes[1] : in_bytes[0];
    keys = '0;
    mask = '0;
    km = '{mapped: 1'b0, cls: hrd_pkg::KEY_PRINTABLE, ch: 7'd0, fn: 4'd0};
    for (int i = 0; i < KEY_SLOTS; i++) begin
      keys[i] = (in_len == 4'd9) ? in_bytes[i + 3] : in_bytes[i + 2];
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_keys_r[j] == keys[i]) begin
          hit = 1'b1;
        end
      end
      km = hrd_pkg::map_key(keys[i], 1'b0);
      mask[i] = (keys[i] != 8'd0) && !hit && km.mapped;
    end

    has_id = (in_len >= 4'd5) && (in_bytes[0] >= 8'd1) && (in_bytes[0] <= 8'd15)
             && (in_bytes[1] <= 8'd7);

    job.is_mouse = is_mouse;
    job.mods = mods;
    job.shifted = (mods & shift_mask) != 8'd0;
    job.mask = mask;
    job.keys = keys;
    job.buttons = has_id ? in_bytes[1][2:0] : in_bytes[0][2:0];
    job.dx = has_id ? in_bytes[2] : in_bytes[1];
    job.dy = has_id ? in_bytes[3] : in_bytes[2];
    if (has_id) begin
      job.wheel = (in_len > 4'd4) ? in_bytes[4] : 8'd0;
    end else begin
      job.wheel = (in_len > 4'd3) ? in_bytes[3] : 8'd0;
    end

    push = accept && (is_mouse || (is_kbd && (mask != '0)));

    prev_keys_nxt = prev_keys_r;
    if (accept && is_kbd) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys_nxt[i] = keys[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '0;
    end else begin
      prev_keys_r <= prev_keys_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/hrd_queue.sv */
`default_nettype none

module hrd_queue (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire hrd_pkg::job_t job_in,
  input  wire logic    pop,
  output logic         full,
  output logic         empty,
  output hrd_pkg::job_t job_out
);

  localparam int PtrBits = (hrd_pkg::QUEUE_DEPTH > 1) ? $clog2(hrd_pkg::QUEUE_DEPTH) : 1;
  localparam int CountBits = $clog2(hrd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CountBits-1:0] DepthCount = CountBits'(hrd_pkg::QUEUE_DEPTH);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(hrd_pkg::QUEUE_DEPTH - 1);

  hrd_pkg::job_t entries_r [hrd_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrBits-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CountBits-1:0] count_r, count_nxt;

  always_comb begin
    full = count_r == DepthCount;
    empty = count_r == '0;
    job_out = entries_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/hrd_back.sv */
`default_nettype none

module hrd_back (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] wheel_scale,
  input  wire logic       q_empty,
  input  wire hrd_pkg::job_t q_job,
  output logic            pop,
  input  wire logic       out_stall,
  output logic            out_valid,
  output hrd_pkg::event_t evt
);

  hrd_pkg::job_t   job_r, job_nxt;
  logic            job_valid_r, job_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  hrd_pkg::event_t evt_r, evt_nxt;
  logic signed [15:0] dx_acc_r, dx_acc_nxt;
  logic signed [15:0] dy_acc_r, dy_acc_nxt;

  logic                                   emit;
  logic                                   last;
  logic [hrd_pkg::MAX_KEY_SLOTS-1:0]      rem;
  logic [hrd_pkg::SLOT_INDEX_BITS-1:0]    idx;
  logic [7:0]                             key;
  hrd_pkg::key_map_t                      km;
  logic signed [12:0]                     wheel_prod;
  logic signed [13:0]                     dy_step;
  logic signed [17:0]                     dx_sum;
  logic signed [17:0]                     dy_sum;

  always_comb begin
    emit = job_valid_r && (!out_valid_r || !out_stall);
    rem = job_r.mask & (job_r.mask - 1'b1);
    last = job_r.is_mouse || (rem == '0);
    pop = !q_empty && (!job_valid_r || (emit && last));

    idx = '0;
    for (int i = hrd_pkg::MAX_KEY_SLOTS - 1; i >= 0; i--) begin
      if (job_r.mask[i]) begin
        idx = hrd_pkg::SLOT_INDEX_BITS'(i);
      end
    end
    key = job_r.keys[idx];
    km = hrd_pkg::map_key(key, job_r.shifted);

    wheel_prod = 13'($signed(job_r.wheel)) * 13'($signed({1'b0, wheel_scale}));
    dy_step = 14'($signed(job_r.dy)) + 14'(wheel_prod);
    dx_sum = 18'(dx_acc_r) + 18'($signed(job_r.dx));
    dy_sum = 18'(dy_acc_r) + 18'(dy_step);

    dx_acc_nxt = dx_acc_r;
    dy_acc_nxt = dy_acc_r;
    if (emit && job_r.is_mouse) begin
      dx_acc_nxt = $signed(hrd_pkg::sat16(dx_sum));
      dy_acc_nxt = $signed(hrd_pkg::sat16(dy_sum));
    end

    evt_nxt = evt_r;
    if (emit) begin
      if (job_r.is_mouse) begin
        evt_nxt.kind = hrd_pkg::EVENT_MOUSE;
        evt_nxt.mods = 8'd0;
        evt_nxt.key_code = 8'd0;
        evt_nxt.key_class = hrd_pkg::KEY_PRINTABLE;
        evt_nxt.char_code = 7'd0;
        evt_nxt.function_number = 4'd0;
        evt_nxt.dx_total = dx_acc_nxt;
        evt_nxt.dy_total = dy_acc_nxt;
        evt_nxt.left = job_r.buttons[0];
        evt_nxt.right = job_r.buttons[1];
        evt_nxt.middle = job_r.buttons[2];
      end else begin
        evt_nxt.kind = hrd_pkg::EVENT_KEY;
        evt_nxt.mods = job_r.mods;
        evt_nxt.key_code = key;
        evt_nxt.key_class = km.cls;
        evt_nxt.char_code = km.ch;
        evt_nxt.function_number = km.fn;
        evt_nxt.dx_total = 16'd0;
        evt_nxt.dy_total = 16'd0;
        evt_nxt.left = 1'b0;
        evt_nxt.right = 1'b0;
        evt_nxt.middle = 1'b0;
      end
      evt_nxt.last = last;
    end

    out_valid_nxt = emit || (out_valid_r && out_stall);

    job_nxt = job_r;
    job_valid_nxt = job_valid_r;
    if (emit) begin
      job_nxt.mask = rem;
      if (last) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      job_nxt = q_job;
      job_valid_nxt = 1'b1;
    end

    out_valid = out_valid_r;
    evt = evt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      dx_acc_r <= '0;
      dy_acc_r <= '0;
    end else begin
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
      dx_acc_r <= dx_acc_nxt;
      dy_acc_r <= dy_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    evt_r <= evt_nxt;
  end

endmodule

`default_nettype wire
